// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared operation and status codes for the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts toward either neighbor
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int DW = 32,
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic [DW-1:0]      new_value,
  input  logic [PW-1:0]      new_priority,
  input  logic               left_stay,
  input  logic               left_valid,
  input  logic [DW-1:0]      left_value,
  input  logic [PW-1:0]      left_priority,
  input  logic               right_valid,
  input  logic [DW-1:0]      right_value,
  input  logic [PW-1:0]      right_priority,
  output logic               stay,
  output logic               valid,
  output logic [DW-1:0]      value,
  output logic [PW-1:0]      priority_q
);
  import spq_pkg::*;

  // entry stays put on insert when it is at or ahead of the new priority
  assign stay = valid && (priority_q <= new_priority);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.enq && !stay) begin
      valid <= left_stay ? 1'b1 : left_valid;
    end else if (cmd.deq) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq && !stay) begin
      if (left_stay) begin
        value      <= new_value;
        priority_q <= new_priority;
      end else begin
        value      <= left_value;
        priority_q <= left_priority;
      end
    end else if (cmd.deq) begin
      value      <= right_value;
      priority_q <= right_priority;
    end
  end

endmodule

// ===== sv/stable_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// bounded sorted queue, lowest priority number first, ties in arrival order
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken at a rising edge with start high and busy low.
//   op 0 inserts item_value/item_priority behind every entry of lower or
//   equal priority, op 1 removes the front entry, op 2 (and 3) only report.
//   the result (head_value, head_priority, is_empty, fill_level, status)
//   appears in the cycle after the transaction, for exactly one cycle, with
//   done high. it cannot be held off.
//   throughput: one transaction per cycle, busy stays low. every slot is a
//   cell that compares its priority with the incoming one in parallel and
//   shifts toward its neighbor in the same cycle, so no walk over the slots
//   is needed.
//   dequeue on an empty queue reports status 1, an insert into a full queue
//   is dropped with status 2; the contents are then unchanged.
//   reset clears every valid bit and the fill count; the queue is empty and
//   usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
  parameter int CAPACITY       = 16,
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [spq_pkg::OP_W-1:0]      op,
  input  logic [DATA_WIDTH-1:0]         item_value,
  input  logic [PRIORITY_WIDTH-1:0]     item_priority,
  output logic                          done,
  output logic [DATA_WIDTH-1:0]         head_value,
  output logic [PRIORITY_WIDTH-1:0]     head_priority,
  output logic                          is_empty,
  output logic [spq_pkg::FILL_W-1:0]    fill_level,
  output logic [spq_pkg::STATUS_W-1:0]  status
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                      accept;
  logic                      full;
  logic                      empty;
  cell_cmd_t                 cmd;
  logic [STATUS_W-1:0]       status_next;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  logic [CAPACITY-1:0]       cell_stay;
  logic [CAPACITY-1:0]       cell_valid;
  logic [DATA_WIDTH-1:0]     cell_value    [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_priority [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = !cell_valid[0];
  assign full   = cell_valid[CAPACITY-1];

  always_comb begin
    cmd         = '0;
    status_next = ST_OK;
    count_next  = count;
    unique case (op)
      OP_ENQUEUE: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.enq    = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.deq    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      OP_QUERY: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                      l_stay;
      logic                      l_valid;
      logic [DATA_WIDTH-1:0]     l_value;
      logic [PRIORITY_WIDTH-1:0] l_priority;
      logic                      r_valid;
      logic [DATA_WIDTH-1:0]     r_value;
      logic [PRIORITY_WIDTH-1:0] r_priority;

      // the front cell sees a virtual neighbor that always stays ahead
      if (g == 0) begin : g_front
        assign l_stay     = 1'b1;
        assign l_valid    = 1'b0;
        assign l_value    = '0;
        assign l_priority = '0;
      end else begin : g_mid
        assign l_stay     = cell_stay[g-1];
        assign l_valid    = cell_valid[g-1];
        assign l_value    = cell_value[g-1];
        assign l_priority = cell_priority[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign r_valid    = 1'b0;
        assign r_value    = '0;
        assign r_priority = '0;
      end else begin : g_body
        assign r_valid    = cell_valid[g+1];
        assign r_value    = cell_value[g+1];
        assign r_priority = cell_priority[g+1];
      end

      spq_cell #(
        .DW (DATA_WIDTH),
        .PW (PRIORITY_WIDTH)
      ) u_cell (
        .clk            (clk),
        .rst            (rst),
        .cmd            (cmd),
        .new_value      (item_value),
        .new_priority   (item_priority),
        .left_stay      (l_stay),
        .left_valid     (l_valid),
        .left_value     (l_value),
        .left_priority  (l_priority),
        .right_valid    (r_valid),
        .right_value    (r_value),
        .right_priority (r_priority),
        .stay           (cell_stay[g]),
        .valid          (cell_valid[g]),
        .value          (cell_value[g]),
        .priority_q     (cell_priority[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // cells already hold the post-transaction state while done is high
  assign is_empty      = empty;
  assign head_value    = empty ? '0 : cell_value[0];
  assign head_priority = empty ? '0 : cell_priority[0];
  assign fill_level    = FILL_W'(count);

endmodule

// ===== tb/sv/stable_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core_tb
// self-checking bench for the sorted priority queue: a short directed run over
// the empty, full and tie cases, then random fill and drain bursts. every
// result is checked against a behavioral sorted-slot model kept in the bench.
// ----------------------------------------------------------------------------
module stable_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DW           = 32;
  localparam int PW           = 8;
  localparam int RANDOM_ITEMS = 1125;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [DW-1:0]   value;
    logic [PW-1:0]   prio;
  } queue_cmd_t;

  typedef struct {
    logic [DW-1:0]       value;
    logic [PW-1:0]       prio;
    logic                empty;
    logic [FILL_W-1:0]   fill;
    logic [STATUS_W-1:0] status;
  } head_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     op = OP_QUERY;
  logic [DW-1:0]       item_value = '0;
  logic [PW-1:0]       item_priority = '0;
  logic                busy;
  logic                done;
  logic [DW-1:0]       head_value;
  logic [PW-1:0]       head_priority;
  logic                is_empty;
  logic [FILL_W-1:0]   fill_level;
  logic [STATUS_W-1:0] status;

  // sorted slot model, front at index 0
  logic [DW-1:0] slot_value [DEPTH];
  logic [PW-1:0] slot_prio  [DEPTH];
  int            slot_count = 0;

  queue_cmd_t   pending_cmds[$];
  head_report_t expected_heads[$];
  queue_cmd_t   next_cmd;
  queue_cmd_t   taken_cmd;
  head_report_t want;
  logic         xfer = 1'b0;
  int           gap_left = 0;
  int           stall_cycles = 0;
  int           err_count = 0;
  int           n_results = 0;
  int           n_insert = 0;
  int           n_dropped = 0;
  int           n_remove = 0;
  int           n_underflow = 0;
  int           n_query = 0;

  always #1 clk = ~clk;

  stable_priority_queue_core #(
    .CAPACITY(DEPTH),
    .DATA_WIDTH(DW),
    .PRIORITY_WIDTH(PW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .item_value(item_value),
    .item_priority(item_priority),
    .done(done),
    .head_value(head_value),
    .head_priority(head_priority),
    .is_empty(is_empty),
    .fill_level(fill_level),
    .status(status)
  );

  // apply one transaction to the slot model and return the head it leaves
  function automatic head_report_t queue_apply(queue_cmd_t cmd);
    head_report_t r;
    int pos;
    int k;
    r.status = ST_OK;
    if (cmd.op == OP_ENQUEUE) begin
      n_insert++;
      if (slot_count >= DEPTH) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        pos = 0;
        // skip every entry of lower or equal priority so ties stay in order
        while (pos < slot_count && slot_prio[pos] <= cmd.prio) pos++;
        for (k = slot_count; k > pos; k--) begin
          slot_value[k] = slot_value[k-1];
          slot_prio[k]  = slot_prio[k-1];
        end
        slot_value[pos] = cmd.value;
        slot_prio[pos]  = cmd.prio;
        slot_count++;
      end
    end else if (cmd.op == OP_DEQUEUE) begin
      n_remove++;
      if (slot_count == 0) begin
        r.status = ST_EMPTY;
        n_underflow++;
      end else begin
        for (k = 1; k < slot_count; k++) begin
          slot_value[k-1] = slot_value[k];
          slot_prio[k-1]  = slot_prio[k];
        end
        slot_count--;
      end
    end else begin
      n_query++;
    end
    r.empty = (slot_count == 0);
    r.value = r.empty ? '0 : slot_value[0];
    r.prio  = r.empty ? '0 : slot_prio[0];
    r.fill  = slot_count[FILL_W-1:0];
    return r;
  endfunction

  task automatic add_cmd(input logic [OP_W-1:0] o, input logic [DW-1:0] v,
                         input logic [PW-1:0] p);
    queue_cmd_t c;
    c.op    = o;
    c.value = v;
    c.prio  = p;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string name, input logic [DW-1:0] exp_v,
                             input logic [DW-1:0] got_v);
    if (got_v !== exp_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  function automatic logic [PW-1:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return PW'($urandom_range(0, 3));
    else if (sel < 7) return PW'($urandom_range(0, 255));
    else if (sel == 7) return '0;
    else if (sel == 8) return '1;
    else return PW'($urandom_range(100, 103));
  endfunction

  // driver: presents the next pending transaction at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else if (start && !xfer) begin
      // hold the current transaction until it is taken
    end else begin
      if (xfer && pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
        gap_left = $urandom_range(1, 16);
      if (gap_left > 0) begin
        gap_left--;
        start         <= 1'b0;
        op            <= OP_W'($urandom_range(0, 3));
        item_value    <= $urandom();
        item_priority <= PW'($urandom_range(0, 255));
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        start         <= 1'b1;
        op            <= next_cmd.op;
        item_value    <= next_cmd.value;
        item_priority <= next_cmd.prio;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted transaction, then checks any result
  always @(posedge clk) begin
    if (rst) begin
      xfer <= 1'b0;
    end else begin
      xfer <= start && !busy;
      if (start && !busy) begin
        taken_cmd.op    = op;
        taken_cmd.value = item_value;
        taken_cmd.prio  = item_priority;
        expected_heads.push_back(queue_apply(taken_cmd));
      end
      if (done) begin
        if (expected_heads.size() == 0) begin
          err_count++;
          $display("%0t: result with no transaction pending", $time);
        end else begin
          want = expected_heads.pop_front();
          n_results++;
          check_field("head_value", want.value, head_value);
          check_field("head_priority", DW'(want.prio), DW'(head_priority));
          check_field("is_empty", DW'(want.empty), DW'(is_empty));
          check_field("fill_level", DW'(want.fill), DW'(fill_level));
          check_field("status", DW'(want.status), DW'(status));
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_heads.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int i;
    int n;
    int mode;
    int burst;
    int r;
    logic [OP_W-1:0] o;
    logic [PW-1:0] p;
    logic [DW-1:0] v;

    // empty queue: report, spare selector, underflow
    add_cmd(OP_QUERY, $urandom(), PW'($urandom_range(0, 255)));
    add_cmd(OP_SPARE, $urandom(), PW'($urandom_range(0, 255)));
    add_cmd(OP_DEQUEUE, $urandom(), PW'($urandom_range(0, 255)));
    // fill to capacity with ties at both priority extremes and in the middle
    for (i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: p = 8'h00;
        1: p = 8'hFF;
        default: p = 8'h80;
      endcase
      v = (i == 0) ? '0 : (i == 1) ? '1 : DW'($urandom());
      add_cmd(OP_ENQUEUE, v, p);
    end
    add_cmd(OP_ENQUEUE, 32'h5A5A_5A5A, 8'h00);
    add_cmd(OP_SPARE, $urandom(), PW'($urandom_range(0, 255)));
    repeat (4) add_cmd(OP_DEQUEUE, $urandom(), PW'($urandom_range(0, 255)));

    // random bursts leaning toward fill, drain or neither
    n = 0;
    while (n < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(4, 40);
      for (i = 0; i < burst && n < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < (mode == 0 ? 70 : mode == 1 ? 25 : 45)) o = OP_ENQUEUE;
        else if (r < 91) o = OP_DEQUEUE;
        else o = $urandom_range(0, 1) ? OP_QUERY : OP_SPARE;
        add_cmd(o, $urandom(), pick_prio());
        n++;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || expected_heads.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d inserts (%0d dropped while full), %0d removals",
             n_results, n_insert, n_dropped, n_remove);
    $display("removals on empty queue: %0d, report-only transactions: %0d",
             n_underflow, n_query);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
